>>> rtl/ptt_pkg.sv
// Shared types, constants and the control program of the pan/tilt tracker.
package ptt_pkg;

  // Pixel and error widths.
  localparam int PIXEL_BITS = 12;
  localparam int ERR_W      = PIXEL_BITS + 1;

  // Frame centre in pixels.
  localparam logic [PIXEL_BITS-1:0] CENTER_X = PIXEL_BITS'(320);
  localparam logic [PIXEL_BITS-1:0] CENTER_Y = PIXEL_BITS'(240);

  // Fixed-point constants (Q1.12 unity, Q8.8 pan and Q6.8 tilt angles).
  localparam logic [12:0] ONE_Q12      = 13'd4096;
  localparam logic [15:0] PAN_MAX_Q8   = 16'd46080;
  localparam logic [13:0] TILT_MAX_Q8  = 14'd11520;
  localparam logic [15:0] PAN_RESET_Q8 = 16'd23040;

  // Register reset values.
  localparam logic [12:0] SMOOTHING_RESET  = 13'd4096;
  localparam logic [15:0] STEP_PAN_RESET   = 16'd46080;
  localparam logic [13:0] STEP_TILT_RESET  = 14'd11520;

  // Configuration register map.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_GAIN_P_PAN   = 3'd0;
  localparam logic [2:0] REG_GAIN_D_PAN   = 3'd1;
  localparam logic [2:0] REG_GAIN_P_TILT  = 3'd2;
  localparam logic [2:0] REG_GAIN_D_TILT  = 3'd3;
  localparam logic [2:0] REG_SMOOTHING    = 3'd4;
  localparam logic [2:0] REG_DEAD_ZONE    = 3'd5;
  localparam logic [2:0] REG_STEP_PAN     = 3'd6;
  localparam logic [2:0] REG_STEP_TILT    = 3'd7;

  typedef struct packed {
    logic [15:0] gain_p_pan;
    logic [15:0] gain_d_pan;
    logic [15:0] gain_p_tilt;
    logic [15:0] gain_d_tilt;
    logic [12:0] smoothing;
    logic [11:0] dead_zone;
    logic [15:0] step_limit_pan;
    logic [13:0] step_limit_tilt;
  } cfg_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_ERR,     // form dead-zoned error and error difference
    OP_MUL_P,   // product <= gain_p * err
    OP_MUL_D,   // acc <= product, product <= gain_d * derr
    OP_CMD,     // command <= clamp(floor(sum / 16))
    OP_MUL_A,   // product <= alpha * command
    OP_MUL_B,   // acc <= product, product <= (1 - alpha) * smoothed step
    OP_ZERO,    // clear acc and product for a zero error
    OP_SMOOTH,  // smoothed step <= floor(sum / 4096)
    OP_POS,     // position update with clamp
    OP_OUT      // hand the angle pair to the output register
  } op_e;

  typedef enum logic [1:0] {
    C_NONE,
    C_ALWAYS,
    C_ZERO,
    C_AXIS0
  } cond_e;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_ERR    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_ZERO   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_SMOOTH = PC_W'(7);

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic en;
    logic axis;
    op_e  op;
  } ctrl_t;

  typedef struct packed {
    logic err_zero;
  } status_t;

  // Control store: one axis program, run once for pan and once for tilt.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_W'(0): w = '{op: OP_ERR,    cond: C_NONE,   target: PC_ERR};
      PC_W'(1): w = '{op: OP_MUL_P,  cond: C_ZERO,   target: PC_ZERO};
      PC_W'(2): w = '{op: OP_MUL_D,  cond: C_NONE,   target: PC_ERR};
      PC_W'(3): w = '{op: OP_CMD,    cond: C_NONE,   target: PC_ERR};
      PC_W'(4): w = '{op: OP_MUL_A,  cond: C_NONE,   target: PC_ERR};
      PC_W'(5): w = '{op: OP_MUL_B,  cond: C_ALWAYS, target: PC_SMOOTH};
      PC_W'(6): w = '{op: OP_ZERO,   cond: C_NONE,   target: PC_ERR};
      PC_W'(7): w = '{op: OP_SMOOTH, cond: C_NONE,   target: PC_ERR};
      PC_W'(8): w = '{op: OP_POS,    cond: C_AXIS0,  target: PC_ERR};
      default:  w = '{op: OP_OUT,    cond: C_NONE,   target: PC_ERR};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/ptt_regs.sv
// Configuration register file with its APB-style access port.
module ptt_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ptt_pkg::cfg_t             cfg_o
);
  import ptt_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_P_PAN:  cfg_d.gain_p_pan      = pwdata[15:0];
        REG_GAIN_D_PAN:  cfg_d.gain_d_pan      = pwdata[15:0];
        REG_GAIN_P_TILT: cfg_d.gain_p_tilt     = pwdata[15:0];
        REG_GAIN_D_TILT: cfg_d.gain_d_tilt     = pwdata[15:0];
        REG_SMOOTHING:   cfg_d.smoothing       = pwdata[12:0];
        REG_DEAD_ZONE:   cfg_d.dead_zone       = pwdata[11:0];
        REG_STEP_PAN:    cfg_d.step_limit_pan  = pwdata[15:0];
        REG_STEP_TILT:   cfg_d.step_limit_tilt = pwdata[13:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gain_p_pan: 16'd0, gain_d_pan: 16'd0, gain_p_tilt: 16'd0,
                 gain_d_tilt: 16'd0, smoothing: SMOOTHING_RESET, dead_zone: 12'd0,
                 step_limit_pan: STEP_PAN_RESET, step_limit_tilt: STEP_TILT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_GAIN_P_PAN:  prdata = {16'd0, cfg_q.gain_p_pan};
      REG_GAIN_D_PAN:  prdata = {16'd0, cfg_q.gain_d_pan};
      REG_GAIN_P_TILT: prdata = {16'd0, cfg_q.gain_p_tilt};
      REG_GAIN_D_TILT: prdata = {16'd0, cfg_q.gain_d_tilt};
      REG_SMOOTHING:   prdata = {19'd0, cfg_q.smoothing};
      REG_DEAD_ZONE:   prdata = {20'd0, cfg_q.dead_zone};
      REG_STEP_PAN:    prdata = {16'd0, cfg_q.step_limit_pan};
      REG_STEP_TILT:   prdata = {18'd0, cfg_q.step_limit_tilt};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/ptt_sequencer.sv
// Microcode sequencer: step counter, axis select and conditional jumps.
module ptt_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_free_i,
  input  ptt_pkg::status_t  status_i,
  output ptt_pkg::ctrl_t    ctrl_o,
  output logic              busy_o
);
  import ptt_pkg::*;

  logic [PC_W-1:0] pc_q;
  logic            axis_q;
  logic            busy_q;
  uword_t          w;
  logic            stall;
  logic            step;
  logic            taken;

  assign w = ucode(pc_q);

  // The last step waits until the output register can take the angle pair.
  assign stall = (w.op == OP_OUT) && !out_free_i;
  assign step  = busy_q && !stall;

  // Jump condition.
  always_comb begin
    case (w.cond)
      C_NONE:   taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_ZERO:   taken = status_i.err_zero;
      C_AXIS0:  taken = !axis_q;
      default:  taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_ERR;
      axis_q <= 1'b0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      pc_q   <= PC_ERR;
      axis_q <= 1'b0;
      busy_q <= 1'b1;
    end else if (step) begin
      if (w.op == OP_OUT) begin
        busy_q <= 1'b0;
      end
      if (w.op == OP_POS && taken) begin
        axis_q <= 1'b1;
      end
      pc_q <= taken ? w.target : pc_q + PC_W'(1);
    end
  end

  assign ctrl_o = '{en: step, axis: axis_q, op: w.op};
  assign busy_o = busy_q;

endmodule

>>> rtl/ptt_datapath.sv
// Shared-multiplier datapath and per-axis state of the tracker.
module ptt_datapath #(
  parameter logic [ptt_pkg::PIXEL_BITS-1:0] CENTER_X = ptt_pkg::CENTER_X,
  parameter logic [ptt_pkg::PIXEL_BITS-1:0] CENTER_Y = ptt_pkg::CENTER_Y
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptt_pkg::cfg_t                 cfg_i,
  input  logic                          load_i,
  input  logic [ptt_pkg::PIXEL_BITS-1:0] target_x_i,
  input  logic [ptt_pkg::PIXEL_BITS-1:0] target_y_i,
  input  ptt_pkg::ctrl_t                ctrl_i,
  output ptt_pkg::status_t              status_o,
  output logic [7:0]                    pan_angle_o,
  output logic [5:0]                    tilt_angle_o
);
  import ptt_pkg::*;

  // Captured item and working registers.
  logic [PIXEL_BITS-1:0]   tx_q, ty_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [ERR_W:0]   derr_q;
  logic signed [31:0]      acc_q, prod_q;
  logic signed [16:0]      cmd_q;
  logic signed [17:0]      s_q;

  // Per-axis state.
  logic signed [ERR_W-1:0] last_err_pan_q, last_err_tilt_q;
  logic signed [17:0]      sstep_pan_q, sstep_tilt_q;
  logic [15:0]             pos_pan_q;
  logic [13:0]             pos_tilt_q;

  // Axis selection.
  logic                    axis;
  logic [PIXEL_BITS-1:0]   tgt, centre;
  logic signed [ERR_W-1:0] last_err, err_raw, err_new;
  logic [ERR_W-1:0]        mag;
  logic [15:0]             gp, gd, limit;
  logic signed [17:0]      sstep;
  logic [15:0]             pos;
  logic [15:0]             pos_max;

  assign axis     = ctrl_i.axis;
  assign tgt      = axis ? ty_q : tx_q;
  assign centre   = axis ? CENTER_Y : CENTER_X;
  assign last_err = axis ? last_err_tilt_q : last_err_pan_q;
  assign gp       = axis ? cfg_i.gain_p_tilt : cfg_i.gain_p_pan;
  assign gd       = axis ? cfg_i.gain_d_tilt : cfg_i.gain_d_pan;
  assign limit    = axis ? {2'b00, cfg_i.step_limit_tilt} : cfg_i.step_limit_pan;
  assign sstep    = axis ? sstep_tilt_q : sstep_pan_q;
  assign pos      = axis ? {2'b00, pos_tilt_q} : pos_pan_q;
  assign pos_max  = axis ? {2'b00, TILT_MAX_Q8} : PAN_MAX_Q8;

  // Error with dead zone.
  assign err_raw = $signed({1'b0, tgt}) - $signed({1'b0, centre});
  assign mag     = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
  assign err_new = (mag < {1'b0, cfg_i.dead_zone}) ? '0 : err_raw;

  // Smoothing weight, saturated at one.
  logic [12:0] alpha, alpha_c;
  assign alpha   = (cfg_i.smoothing > ONE_Q12) ? ONE_Q12 : cfg_i.smoothing;
  assign alpha_c = ONE_Q12 - alpha;

  // Shared multiplier with operand selection.
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [34:0] mul_p;
  always_comb begin
    case (ctrl_i.op)
      OP_MUL_P: begin
        mul_a = $signed({1'b0, gp});
        mul_b = 18'(err_q);
      end
      OP_MUL_D: begin
        mul_a = $signed({1'b0, gd});
        mul_b = 18'(derr_q);
      end
      OP_MUL_A: begin
        mul_a = $signed({4'b0, alpha});
        mul_b = 18'(cmd_q);
      end
      default: begin
        mul_a = $signed({4'b0, alpha_c});
        mul_b = sstep;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Sum of the two partial terms, then the scaled forms.
  logic signed [31:0] sum, sh4, lim;
  logic signed [16:0] cmd_new;
  logic signed [18:0] pos_diff;
  logic [15:0]        pos_new;
  assign sum = acc_q + prod_q;
  assign sh4 = sum >>> 4;
  assign lim = $signed({16'd0, limit});

  always_comb begin
    if (sh4 > lim) begin
      cmd_new = lim[16:0];
    end else if (sh4 < -lim) begin
      cmd_new = 17'(-lim);
    end else begin
      cmd_new = sh4[16:0];
    end
  end

  // Position update with clamp to the axis range.
  assign pos_diff = $signed({3'b000, pos}) - $signed({s_q[17], s_q});
  always_comb begin
    if (pos_diff < 0) begin
      pos_new = 16'd0;
    end else if (pos_diff > $signed({3'b000, pos_max})) begin
      pos_new = pos_max;
    end else begin
      pos_new = pos_diff[15:0];
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tx_q <= target_x_i;
      ty_q <= target_y_i;
    end
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        OP_ERR: begin
          err_q  <= err_new;
          derr_q <= (ERR_W+1)'(err_new) - (ERR_W+1)'(last_err);
        end
        OP_MUL_P, OP_MUL_A: prod_q <= mul_p[31:0];
        OP_MUL_D, OP_MUL_B: begin
          acc_q  <= prod_q;
          prod_q <= mul_p[31:0];
        end
        OP_CMD: cmd_q <= cmd_new;
        OP_ZERO: begin
          acc_q  <= '0;
          prod_q <= '0;
        end
        OP_SMOOTH: s_q <= 18'(sum >>> 12);
        default: ;
      endcase
    end
  end

  // Axis state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_pan_q  <= '0;
      last_err_tilt_q <= '0;
      sstep_pan_q     <= '0;
      sstep_tilt_q    <= '0;
      pos_pan_q       <= PAN_RESET_Q8;
      pos_tilt_q      <= '0;
    end else if (ctrl_i.en) begin
      if (ctrl_i.op == OP_ERR) begin
        if (axis) begin
          last_err_tilt_q <= err_new;
        end else begin
          last_err_pan_q  <= err_new;
        end
      end
      if (ctrl_i.op == OP_SMOOTH) begin
        if (axis) begin
          sstep_tilt_q <= 18'(sum >>> 12);
        end else begin
          sstep_pan_q  <= 18'(sum >>> 12);
        end
      end
      if (ctrl_i.op == OP_POS) begin
        if (axis) begin
          pos_tilt_q <= pos_new[13:0];
        end else begin
          pos_pan_q  <= pos_new;
        end
      end
    end
  end

  assign status_o.err_zero = (err_q == '0);

  // Round half up to whole degrees.
  logic [16:0] pan_r;
  logic [14:0] tilt_r;
  assign pan_r        = {1'b0, pos_pan_q} + 17'd128;
  assign tilt_r       = {1'b0, pos_tilt_q} + 15'd128;
  assign pan_angle_o  = pan_r[15:8];
  assign tilt_angle_o = tilt_r[13:8];

endmodule

>>> rtl/pan_tilt_pd_tracker_top.sv
// Top level of the pan/tilt PD tracker: ports, handshake and output register.
//
// Usage: one face position per frame enters on the slave stream (target_x in
// s_axis_tdata[11:0], target_y in [23:12]). One pan/tilt angle pair leaves on
// the master stream (pan_angle in m_axis_tdata[7:0], tilt_angle in [13:8]).
// Gains, smoothing, dead zone and step limits are set through the APB-style
// port at byte addresses 0x00 to 0x1C; write them only while the block is idle.
// The time from acceptance to a valid result is set by the control program:
// eight steps per axis, five for an axis whose error is zero, and one step to
// load the output register, all through one shared 17 x 18 multiplier. One
// item is in work at a time; s_axis_tready is high whenever the sequencer is
// idle, also while a result waits in the output register, so the next item
// can be taken in the same cycle as a result appears. If the receiver stalls,
// the next item runs until its final step and holds there until the output
// register is free.
// Reset clears the registers to their documented values, the pan position to
// 90 degrees and the tilt position to 0 degrees, and empties the output.
module pan_tilt_pd_tracker_top #(
  parameter logic [ptt_pkg::PIXEL_BITS-1:0] CENTER_X = ptt_pkg::CENTER_X,
  parameter logic [ptt_pkg::PIXEL_BITS-1:0] CENTER_Y = ptt_pkg::CENTER_Y
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Slave stream: [11:0] target_x, [23:12] target_y.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,
  // Master stream: [7:0] pan_angle, [13:8] tilt_angle, [15:14] zero.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ptt_pkg::*;

  cfg_t       cfg;
  ctrl_t      ctrl;
  status_t    status;
  logic       busy;
  logic       start;
  logic       out_free;
  logic       out_load;
  logic [7:0] pan_angle;
  logic [5:0] tilt_angle;

  logic        m_valid_q;
  logic [15:0] m_data_q;

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && !busy;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = ctrl.en && (ctrl.op == OP_OUT);

  ptt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptt_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  ptt_datapath #(
    .CENTER_X (CENTER_X),
    .CENTER_Y (CENTER_Y)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .load_i       (start),
    .target_x_i   (s_axis_tdata[11:0]),
    .target_y_i   (s_axis_tdata[23:12]),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .pan_angle_o  (pan_angle),
    .tilt_angle_o (tilt_angle)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {2'b00, tilt_angle, pan_angle};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // An accepted item always starts the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer did not start on an accepted item");

  // A result appears only as the sequencer finishes its program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> (!busy && $past(busy)))
    else $error("result appeared outside the end of a program run");

  // Angles stay inside the servo ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[7:0] <= 8'd180 && m_data_q[13:8] <= 6'd45))
    else $error("angle out of range");

endmodule
